FILE: hdl/assert_macros.svh
// Assertion macros used by the record parser module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/tver_pkg.sv
// Types and constants of the tagged varint edit record parser.
package tver_pkg;

    // Parse phase of the record.
    typedef enum logic [3:0] {
        PH_TAG   = 4'd0,
        PH_VAL   = 4'd1,
        PH_DLEV  = 4'd2,
        PH_DNUM  = 4'd3,
        PH_NLEV  = 4'd4,
        PH_NNUM  = 4'd5,
        PH_NSIZE = 4'd6,
        PH_SLEN  = 4'd7,
        PH_SKEY  = 4'd8,
        PH_LLEN  = 4'd9,
        PH_LKEY  = 4'd10
    } phase_t;

    // Result kinds.
    localparam logic [3:0] KIND_DELETED  = 4'd4;
    localparam logic [3:0] KIND_NEWFILE  = 4'd5;
    localparam logic [3:0] KIND_SMALLEST = 4'd6;
    localparam logic [3:0] KIND_LARGEST  = 4'd7;
    localparam logic [3:0] KIND_STATUS   = 4'd8;

    // Status codes; field errors carry the tag number itself.
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_UNKNOWN_TAG = 4'd7;
    localparam logic [3:0] ST_BAD_TAG     = 4'd8;

    // Tag values.
    localparam logic [2:0] TAG_DELETED = 3'd5;

    // Varint byte limits.
    localparam logic [3:0] LIMIT_32 = 4'd5;
    localparam logic [3:0] LIMIT_64 = 4'd10;

    // Result queue geometry.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    // One result item.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] level;
        logic [63:0] value;
        logic [63:0] size_bytes;
        logic [7:0]  key_byte;
        logic        key_end;
        logic [3:0]  status;
        logic        run_last;
    } result_t;

endpackage

FILE: hdl/tagged_varint_edit_record_parser.sv
// Tagged varint edit record parser: byte-serial decoder with a small result queue.
//
// The parser takes one record byte per cycle while in_ready is high and updates
// its state in the same cycle; results are written into a four-entry register
// queue and appear on the output at the earliest in the cycle after the byte is
// taken. While out_ready stays high the sustained rate is one byte per clock.
// A byte gives at most one field result, plus a status result when it carries
// the end-of-record mark, so the output side delivers one result per clock and
// in_ready falls only while the queue has fewer than two free entries.
// No clearing pass is needed after reset.
`include "assert_macros.svh"

module tagged_varint_edit_record_parser
    import tver_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_record,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [31:0] level,
    output logic [63:0] value,
    output logic [63:0] size_bytes,
    output logic [7:0]  key_byte,
    output logic        key_end,
    output logic [3:0]  status,
    output logic        run_last
);

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [2:0]  tag_reg, tag_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] lev_reg, lev_next;
    logic [63:0] num_reg, num_next;
    logic [31:0] left_reg, left_next;
    logic [3:0]  err_reg, err_next;

    // Result queue.
    result_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic        in_fire, pop;
    logic        field_vld;
    result_t     field_res, stat_res, res0, res1;
    logic [1:0]  push_n;

    // Varint feed terms.
    logic [6:0]  shamt;
    logic [63:0] acc_fed;
    logic [3:0]  cnt_fed;
    logic        is32;
    logic [3:0]  limit;
    logic        vdone, vover;
    logic        last_key;
    logic [31:0] tag_val;
    logic [3:0]  trunc_st;

    assign in_fire = in_valid && in_ready;
    assign pop     = out_valid && out_ready;

    // Shift the low seven bits of the byte into place above those already held.
    assign shamt   = {cnt_reg, 3'b000} - {3'b000, cnt_reg};
    assign acc_fed = acc_reg | ({57'd0, data_byte[6:0]} << shamt[5:0]);
    assign cnt_fed = cnt_reg + 4'd1;
    assign is32    = (phase_reg == PH_TAG) || (phase_reg == PH_DLEV) ||
                     (phase_reg == PH_NLEV) || (phase_reg == PH_SLEN) ||
                     (phase_reg == PH_LLEN);
    assign limit   = is32 ? LIMIT_32 : LIMIT_64;
    assign vdone   = !data_byte[7];
    assign vover   = data_byte[7] && (cnt_fed >= limit);
    assign tag_val = acc_fed[31:0];
    assign last_key = (left_reg <= 32'd1);

    // Parser next state and the field result of this byte.
    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        lev_next   = lev_reg;
        num_next   = num_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        field_vld  = 1'b0;
        field_res  = '0;
        trunc_st   = ST_OK;

        if (err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_TAG, PH_VAL, PH_DLEV, PH_DNUM, PH_NLEV, PH_NNUM, PH_NSIZE,
                PH_SLEN, PH_LLEN:
                begin
                    acc_next = acc_fed;
                    cnt_next = cnt_fed;
                    if (vover)
                    begin
                        err_next = (phase_reg == PH_TAG) ? ST_BAD_TAG : {1'b0, tag_reg};
                    end
                    else if (vdone)
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                        case (phase_reg)
                            PH_TAG:
                            begin
                                if (tag_val >= 32'd1 && tag_val <= 32'd6)
                                begin
                                    tag_next = tag_val[2:0];
                                    if (tag_val <= 32'd4)
                                        phase_next = PH_VAL;
                                    else if (tag_val[2:0] == TAG_DELETED)
                                        phase_next = PH_DLEV;
                                    else
                                        phase_next = PH_NLEV;
                                end
                                else
                                begin
                                    err_next = ST_UNKNOWN_TAG;
                                end
                            end
                            PH_VAL:
                            begin
                                field_vld       = 1'b1;
                                field_res.kind  = {2'b00, 2'(tag_reg - 3'd1)};
                                field_res.value = acc_fed;
                                phase_next      = PH_TAG;
                            end
                            PH_DNUM:
                            begin
                                field_vld       = 1'b1;
                                field_res.kind  = KIND_DELETED;
                                field_res.level = lev_reg;
                                field_res.value = acc_fed;
                                phase_next      = PH_TAG;
                            end
                            PH_NNUM:
                            begin
                                num_next   = acc_fed;
                                phase_next = PH_NSIZE;
                            end
                            PH_NSIZE:
                            begin
                                field_vld            = 1'b1;
                                field_res.kind       = KIND_NEWFILE;
                                field_res.level      = lev_reg;
                                field_res.value      = num_reg;
                                field_res.size_bytes = acc_fed;
                                phase_next           = PH_SLEN;
                            end
                            PH_DLEV:
                            begin
                                lev_next   = tag_val;
                                phase_next = PH_DNUM;
                            end
                            PH_NLEV:
                            begin
                                lev_next   = tag_val;
                                phase_next = PH_NNUM;
                            end
                            default:
                            begin
                                // Key length of the smallest or largest key.
                                left_next = tag_val;
                                if (tag_val == 32'd0)
                                begin
                                    field_vld         = 1'b1;
                                    field_res.kind    = (phase_reg == PH_SLEN) ?
                                                        KIND_SMALLEST : KIND_LARGEST;
                                    field_res.key_end = 1'b1;
                                    phase_next = (phase_reg == PH_SLEN) ? PH_LLEN : PH_TAG;
                                end
                                else
                                begin
                                    phase_next = (phase_reg == PH_SLEN) ? PH_SKEY : PH_LKEY;
                                end
                            end
                        endcase
                    end
                end
                PH_SKEY, PH_LKEY:
                begin
                    field_vld          = 1'b1;
                    field_res.kind     = (phase_reg == PH_SKEY) ? KIND_SMALLEST : KIND_LARGEST;
                    field_res.value    = 64'd1;
                    field_res.key_byte = data_byte;
                    field_res.key_end  = last_key;
                    left_next          = last_key ? 32'd0 : left_reg - 32'd1;
                    if (last_key)
                        phase_next = (phase_reg == PH_SKEY) ? PH_LLEN : PH_TAG;
                end
                default:
                begin
                    phase_next = PH_TAG;
                end
            endcase
        end

        // Status at end of record: the first error, else any truncation.
        if (err_next != ST_OK)
            trunc_st = err_next;
        else if (phase_next != PH_TAG)
            trunc_st = {1'b0, tag_next};
        else if (cnt_next != 4'd0)
            trunc_st = ST_BAD_TAG;

        field_res.run_last = !end_of_record;

        if (end_of_record)
        begin
            phase_next = PH_TAG;
            tag_next   = '0;
            acc_next   = '0;
            cnt_next   = '0;
            lev_next   = '0;
            num_next   = '0;
            left_next  = '0;
            err_next   = ST_OK;
        end
    end

    // Status result and the order of the results into the queue.
    always_comb
    begin
        stat_res          = '0;
        stat_res.kind     = KIND_STATUS;
        stat_res.status   = trunc_st;
        stat_res.run_last = 1'b1;
        res0   = field_vld ? field_res : stat_res;
        res1   = stat_res;
        push_n = in_fire ? ({1'b0, field_vld} + {1'b0, end_of_record}) : 2'd0;
    end

    // Queue pointers and occupancy.
    always_comb
    begin
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = tail_reg + QPTR_W'(push_n);
        count_next = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    assign in_ready  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (count_reg != '0);

    // Parser and queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            tag_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            lev_reg   <= '0;
            num_reg   <= '0;
            left_reg  <= '0;
            err_reg   <= ST_OK;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg <= phase_next;
                tag_reg   <= tag_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                lev_reg   <= lev_next;
                num_reg   <= num_next;
                left_reg  <= left_next;
                err_reg   <= err_next;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[tail_reg] <= res0;
        if (push_n == 2'd2)
            mem_reg[tail_reg + 1'b1] <= res1;
    end

    // Output fields come from the head of the queue.
    assign kind       = mem_reg[head_reg].kind;
    assign level      = mem_reg[head_reg].level;
    assign value      = mem_reg[head_reg].value;
    assign size_bytes = mem_reg[head_reg].size_bytes;
    assign key_byte   = mem_reg[head_reg].key_byte;
    assign key_end    = mem_reg[head_reg].key_end;
    assign status     = mem_reg[head_reg].status;
    assign run_last   = mem_reg[head_reg].run_last;

    // The queue never takes more results than it has room for.
    `ASSERT_IMPL(a_no_overflow, clk, rst_n, in_fire, count_reg + QCNT_W'(push_n) <= QCNT_W'(QDEPTH))

    // An end-of-record byte leaves the parser in its reset state.
    `ASSERT_NEXT(a_eor_resets, clk, rst_n, in_fire && end_of_record, phase_reg == PH_TAG && err_reg == ST_OK && cnt_reg == 4'd0)

    // Once set, an error is kept until the end of the record.
    `ASSERT_NEXT(a_error_sticks, clk, rst_n, err_reg != ST_OK && !(in_fire && end_of_record), $stable(err_reg))

endmodule

FILE: tb/sv/tb_tagged_varint_edit_record_parser.sv
// Self-checking testbench for the tagged varint edit record parser.
`timescale 1ns / 100ps

import tver_pkg::*;

// Tag numbers of an edit record; the deleted-file tag comes from the package.
localparam logic [2:0] TAG_LOG      = 3'd1;
localparam logic [2:0] TAG_LASTSEQ  = 3'd4;
localparam logic [2:0] TAG_NEWFILE  = 3'd6;

// Outcome of feeding one byte into a varint.
typedef enum int {
    VARINT_MORE,
    VARINT_DONE,
    VARINT_OVERLONG
} varint_step_t;

// Mirrors the parser state and holds the results that each request should cause.
class edit_record_scoreboard;
    phase_t      phase;
    logic [2:0]  tag;
    logic [63:0] accum;
    int unsigned accum_bytes;
    logic [31:0] held_level;
    logic [63:0] held_number;
    logic [31:0] key_left;
    logic [3:0]  first_error;
    result_t     step_results[$];
    result_t     awaited_results[$];
    int unsigned parsed_bytes;
    int unsigned checked;
    int unsigned errors;

    function new();
        parsed_bytes = 0;
        checked = 0;
        errors = 0;
        restart();
    endfunction

    // State at reset and after each end of record.
    function void restart();
        phase = PH_TAG;
        tag = 3'd0;
        accum = 64'd0;
        accum_bytes = 0;
        held_level = 32'd0;
        held_number = 64'd0;
        key_left = 32'd0;
        first_error = ST_OK;
    endfunction

    function int unsigned pending();
        return awaited_results.size();
    endfunction

    // Adds one LEB128 byte; bits above the width are dropped on completion.
    function varint_step_t feed(logic [7:0] b, logic [3:0] limit);
        if (accum_bytes < 10)
            accum = accum | ({57'd0, b[6:0]} << (7 * accum_bytes));
        accum_bytes++;
        if (!b[7]) begin
            if (limit == LIMIT_32)
                accum = accum & 64'h0000_0000_FFFF_FFFF;
            return VARINT_DONE;
        end
        if (accum_bytes >= limit)
            return VARINT_OVERLONG;
        return VARINT_MORE;
    endfunction

    function logic [63:0] take_varint();
        logic [63:0] v;
        v = accum;
        accum = 64'd0;
        accum_bytes = 0;
        return v;
    endfunction

    function void emit(logic [3:0] kind, logic [31:0] level, logic [63:0] value,
                       logic [63:0] size_bytes, logic [7:0] key_byte, logic key_end,
                       logic [3:0] status);
        result_t r;
        r.kind = kind;
        r.level = level;
        r.value = value;
        r.size_bytes = size_bytes;
        r.key_byte = key_byte;
        r.key_end = key_end;
        r.status = status;
        r.run_last = 1'b0;
        step_results.push_back(r);
    endfunction

    // Works out the results of one accepted request.
    function void absorb_byte(logic [7:0] b, logic eor);
        varint_step_t step;
        logic [63:0]  v;
        logic [3:0]   st;
        logic         is_small;
        logic         last_key;
        result_t      r;
        step_results.delete();
        if (first_error == ST_OK || eor)
            parsed_bytes++;
        if (first_error == ST_OK) begin
            case (phase)
                PH_TAG: begin
                    step = feed(b, LIMIT_32);
                    if (step == VARINT_OVERLONG) begin
                        first_error = ST_BAD_TAG;
                    end else if (step == VARINT_DONE) begin
                        v = take_varint();
                        if (v >= TAG_LOG && v <= TAG_NEWFILE) begin
                            tag = v[2:0];
                            if (v <= TAG_LASTSEQ)
                                phase = PH_VAL;
                            else if (v == TAG_DELETED)
                                phase = PH_DLEV;
                            else
                                phase = PH_NLEV;
                        end else begin
                            first_error = ST_UNKNOWN_TAG;
                        end
                    end
                end
                PH_VAL, PH_DNUM, PH_NNUM, PH_NSIZE: begin
                    step = feed(b, LIMIT_64);
                    if (step == VARINT_OVERLONG) begin
                        first_error = {1'b0, tag};
                    end else if (step == VARINT_DONE) begin
                        v = take_varint();
                        case (phase)
                            PH_VAL: begin
                                emit({1'b0, tag - 3'd1}, 32'd0, v, 64'd0, 8'd0, 1'b0, ST_OK);
                                phase = PH_TAG;
                            end
                            PH_DNUM: begin
                                emit(KIND_DELETED, held_level, v, 64'd0, 8'd0, 1'b0, ST_OK);
                                phase = PH_TAG;
                            end
                            PH_NNUM: begin
                                held_number = v;
                                phase = PH_NSIZE;
                            end
                            default: begin
                                emit(KIND_NEWFILE, held_level, held_number, v, 8'd0, 1'b0,
                                     ST_OK);
                                phase = PH_SLEN;
                            end
                        endcase
                    end
                end
                PH_DLEV, PH_NLEV, PH_SLEN, PH_LLEN: begin
                    step = feed(b, LIMIT_32);
                    if (step == VARINT_OVERLONG) begin
                        first_error = {1'b0, tag};
                    end else if (step == VARINT_DONE) begin
                        v = take_varint();
                        if (phase == PH_DLEV) begin
                            held_level = v[31:0];
                            phase = PH_DNUM;
                        end else if (phase == PH_NLEV) begin
                            held_level = v[31:0];
                            phase = PH_NNUM;
                        end else begin
                            is_small = (phase == PH_SLEN);
                            key_left = v[31:0];
                            if (v == 64'd0) begin
                                // An empty key still gives one closing result.
                                emit(is_small ? KIND_SMALLEST : KIND_LARGEST, 32'd0, 64'd0,
                                     64'd0, 8'd0, 1'b1, ST_OK);
                                if (is_small)
                                    phase = PH_LLEN;
                                else
                                    phase = PH_TAG;
                            end else if (is_small) begin
                                phase = PH_SKEY;
                            end else begin
                                phase = PH_LKEY;
                            end
                        end
                    end
                end
                PH_SKEY, PH_LKEY: begin
                    is_small = (phase == PH_SKEY);
                    last_key = (key_left <= 32'd1);
                    emit(is_small ? KIND_SMALLEST : KIND_LARGEST, 32'd0, 64'd1, 64'd0, b,
                         last_key, ST_OK);
                    key_left = last_key ? 32'd0 : key_left - 32'd1;
                    if (last_key) begin
                        if (is_small)
                            phase = PH_LLEN;
                        else
                            phase = PH_TAG;
                    end
                end
                default: phase = PH_TAG;
            endcase
        end

        // End of record: report the first error, or a truncation, then start over.
        if (eor) begin
            st = first_error;
            if (st == ST_OK && (phase != PH_TAG || accum_bytes != 0))
                st = (phase == PH_TAG) ? ST_BAD_TAG : {1'b0, tag};
            emit(KIND_STATUS, 32'd0, 64'd0, 64'd0, 8'd0, 1'b0, st);
            restart();
        end

        for (int i = 0; i < step_results.size(); i++) begin
            r = step_results[i];
            r.run_last = (i == step_results.size() - 1);
            awaited_results.push_back(r);
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got %h, expected %h", checked, name, got, want));
    endtask

    task check_result(result_t got);
        result_t want;
        if (awaited_results.size() == 0) begin
            report($sformatf("result %0d of kind %0d arrived with none awaited",
                             checked, got.kind));
        end else begin
            want = awaited_results.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("level", got.level, want.level);
            compare_field("value", got.value, want.value);
            compare_field("size_bytes", got.size_bytes, want.size_bytes);
            compare_field("key_byte", got.key_byte, want.key_byte);
            compare_field("key_end", got.key_end, want.key_end);
            compare_field("status", got.status, want.status);
            compare_field("run_last", got.run_last, want.run_last);
        end
        checked++;
    endtask

    task close_out();
        if (awaited_results.size() != 0)
            report($sformatf("%0d results never arrived", awaited_results.size()));
    endtask
endclass

module tb_tagged_varint_edit_record_parser;

    localparam int unsigned IDLE_PCT      = 26;
    localparam int unsigned RANDOM_ITEMS  = 1800;
    localparam int unsigned STEADY_FROM   = 700;
    localparam int unsigned STEADY_TO     = 1000;
    // Results appear in the cycle after the byte at the earliest; the drain covers any slack.
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned QUIET_LIMIT   = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_record;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  kind;
    logic [31:0] level;
    logic [63:0] value;
    logic [63:0] size_bytes;
    logic [7:0]  key_byte;
    logic        key_end;
    logic [3:0]  status;
    logic        run_last;

    logic        steady;
    int unsigned quiet_cycles;
    int unsigned random_base;
    logic [7:0]  record_bytes[$];

    edit_record_scoreboard sb;

    tagged_varint_edit_record_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_record (end_of_record),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .level         (level),
        .value         (value),
        .size_bytes    (size_bytes),
        .key_byte      (key_byte),
        .key_end       (key_end),
        .status        (status),
        .run_last      (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: stalls at random except during the steady stretch.
    always @(posedge clk)
    begin
        if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Requests are noted before results are checked, both as sampled at the edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.absorb_byte(data_byte, end_of_record);
            if (out_valid && out_ready)
                sb.check_result({kind, level, value, size_bytes, key_byte, key_end, status,
                                 run_last});
        end
    end

    // Watchdog on cycles in which neither side moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Random number of 0 to max_bits significant bits, all ones now and then.
    function automatic logic [63:0] rand_number(input int unsigned max_bits);
        logic [63:0] r;
        int unsigned w;
        r = {$urandom, $urandom};
        w = $urandom_range(0, max_bits);
        if ($urandom_range(0, 9) == 0)
            w = max_bits;
        if ($urandom_range(0, 9) == 0)
            r = {64{1'b1}};
        if (w == 0)
            return 64'd0;
        if (w >= 64)
            return r;
        return r & ((64'd1 << w) - 64'd1);
    endfunction

    // LEB128 encoding, sometimes padded, with junk in the bits that the last
    // allowed byte drops.
    function automatic void put_varint(input logic [63:0] v, input logic [3:0] limit);
        int unsigned len;
        logic [63:0] rest;
        logic [7:0]  b;
        len = 1;
        rest = v >> 7;
        while (rest != 64'd0) begin
            len++;
            rest = rest >> 7;
        end
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(len, limit);
        for (int i = 0; i < len; i++) begin
            rest = v >> (7 * i);
            b = {1'b0, rest[6:0]};
            if (i == limit - 1) begin
                if (limit == LIMIT_32)
                    b[6:4] = $urandom_range(0, 7);
                else
                    b[6:1] = $urandom_range(0, 63);
            end
            if (i < len - 1)
                b[7] = 1'b1;
            record_bytes.push_back(b);
        end
    endfunction

    // A varint that never ends within its limit.
    function automatic void put_overlong(input logic [3:0] limit);
        repeat (limit)
            record_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
    endfunction

    function automatic void put_noise(input int unsigned count);
        repeat (count)
            record_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Key lengths are mostly short, sometimes empty, rarely a few dozen bytes.
    function automatic void put_key();
        int unsigned klen;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: klen = 0;
            19:         klen = $urandom_range(8, 40);
            default:    klen = $urandom_range(1, 6);
        endcase
        put_varint(klen, LIMIT_32);
        put_noise(klen);
    endfunction

    // One tag and its fields; with make_bad one field varint runs over its limit.
    function automatic void put_entry(input logic make_bad);
        logic [2:0]  t;
        int unsigned nfields;
        int unsigned bad;
        logic        is_key;
        logic        narrow;
        t = $urandom_range(TAG_LOG, TAG_NEWFILE);
        put_varint({61'd0, t}, LIMIT_32);
        if (t <= TAG_LASTSEQ)
            nfields = 1;
        else if (t == TAG_DELETED)
            nfields = 2;
        else
            nfields = 5;
        bad = make_bad ? $urandom_range(0, nfields - 1) : nfields;
        for (int f = 0; f < nfields; f++) begin
            is_key = (t == TAG_NEWFILE && f >= 3);
            narrow = is_key || (f == 0 && t >= TAG_DELETED);
            if (f == bad) begin
                put_overlong(narrow ? LIMIT_32 : LIMIT_64);
                return;
            end
            if (is_key)
                put_key();
            else if (narrow)
                put_varint(rand_number(32), LIMIT_32);
            else
                put_varint(rand_number(64), LIMIT_64);
        end
    endfunction

    // Mostly well-formed records; the rest truncated, broken or plain noise.
    function automatic void build_random_record();
        int unsigned style;
        int unsigned cut;
        logic [63:0] bad_tag;
        record_bytes.delete();
        style = $urandom_range(0, 99);
        repeat ($urandom_range(0, 4))
            put_entry(1'b0);
        if (style < 70) begin
            put_entry(1'b0);
        end else if (style < 78) begin
            put_entry(1'b0);
            cut = $urandom_range(1, record_bytes.size());
            while (record_bytes.size() > cut)
                record_bytes.delete(record_bytes.size() - 1);
        end else if (style < 85) begin
            put_entry(1'b1);
            put_noise($urandom_range(0, 3));
        end else if (style < 92) begin
            if ($urandom_range(0, 1) == 0) begin
                put_overlong(LIMIT_32);
            end else begin
                case ($urandom_range(0, 2))
                    0:       bad_tag = 64'd0;
                    1:       bad_tag = $urandom_range(TAG_NEWFILE + 1, 127);
                    default: bad_tag = {32'd0, $urandom} | 64'h80;
                endcase
                put_varint(bad_tag, LIMIT_32);
            end
            put_noise($urandom_range(0, 3));
        end else begin
            put_noise($urandom_range(1, 12));
        end
    endfunction

    // Offers one byte, after a random idle gap, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_record <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_record();
        for (int i = 0; i < record_bytes.size(); i++)
            send_byte(record_bytes[i], i == record_bytes.size() - 1);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        end_of_record = 1'b0;
        out_ready = 1'b0;
        steady = 1'b0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Log number zero, with the status on the same byte.
        record_bytes = '{TAG_LOG, 8'h00};
        send_record();
        // New file header, empty smallest key, one-byte largest key.
        record_bytes = '{TAG_NEWFILE, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01, 8'hFF};
        send_record();
        // Unknown tag.
        record_bytes = '{TAG_NEWFILE + 3'd1};
        send_record();
        // Record cut inside a field.
        record_bytes = '{TAG_DELETED, 8'h80};
        send_record();
        // Record cut inside the tag varint.
        record_bytes = '{8'h80};
        send_record();
        // Overlong tag, then a byte that must be ignored.
        record_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h01};
        send_record();
        // Overlong level of a deleted-file entry.
        record_bytes = '{TAG_DELETED, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_record();

        // Random records; only bytes that the parser acts on are counted.
        random_base = sb.parsed_bytes;
        while (sb.parsed_bytes - random_base < RANDOM_ITEMS) begin
            steady <= (sb.parsed_bytes - random_base >= STEADY_FROM) &&
                      (sb.parsed_bytes - random_base < STEADY_TO);
            build_random_record();
            send_record();
        end
        in_valid <= 1'b0;
        steady <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
